// ===== rtl/core/rgbl_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbl_pkg
// Types and constants shared by the rgb led button mode controller.
// ----------------------------------------------------------------------------
package rgbl_pkg;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_SHORT = 2'd1,
    CLS_LONG  = 2'd2,
    CLS_HELD  = 2'd3
  } press_cls_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_PLAN,
    ST_CHAN,
    ST_SCALE,
    ST_OUT
  } seq_state_t;

  localparam logic [1:0]  REG_PWM_PERIOD  = 2'd0;
  localparam logic [1:0]  REG_LONG_TICKS  = 2'd1;
  localparam logic [1:0]  REG_SHORT_TICKS = 2'd2;

  // ceil(2^34 / 1000), exact divide by 1000 for any 24-bit product
  localparam logic [24:0] SCALE_RECIP     = 25'd17179870;
  localparam logic [7:0]  LEVEL_RESET     = 8'd83;
  localparam logic [7:0]  LEVEL_STEP      = 8'd10;
  localparam logic [7:0]  LEVEL_MIN       = 8'd10;
  localparam logic [7:0]  LEVEL_TOP_EDGE  = 8'd240;
  localparam logic [7:0]  LEVEL_MAX       = 8'd254;
  localparam logic [6:0]  PERIOD_RESET    = 7'd50;
  localparam logic [6:0]  PERIOD_STEP     = 7'd5;
  localparam logic [6:0]  PERIOD_MIN      = 7'd5;
  localparam logic [6:0]  PERIOD_LOW_EDGE = 7'd10;
  localparam logic [6:0]  PERIOD_MAX      = 7'd100;
  localparam logic [3:0]  COLOUR_RESET    = 4'd2;
  localparam logic [15:0] WIDTH_RESET     = 16'd943;
  localparam logic [15:0] WIDTH_OFF       = 16'd1;
  localparam logic [15:0] HOLD_MAX        = 16'hFFFF;

  function automatic logic [3:0] next_colour(input logic [3:0] c);
    logic [3:0] n;
    case (c)
      4'd2:    n = 4'd10;
      4'd10:   n = 4'd8;
      4'd8:    n = 4'd12;
      4'd12:   n = 4'd4;
      4'd4:    n = 4'd6;
      4'd6:    n = 4'd2;
      default: n = c;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/rgbl_scale.sv =====
// ----------------------------------------------------------------------------
// rgbl_scale
// Level to pulse width: one multiply, then a reciprocal multiply for the
// divide by 1000; done follows start through mul_v_r and then done_r.
// ----------------------------------------------------------------------------
module rgbl_scale
  import rgbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [7:0]  level,
  input  logic [15:0] period,
  output logic        done,
  output logic [15:0] result
);

  logic [23:0] prod_r;
  logic [15:0] quot_r;
  logic        mul_v_r;
  logic        done_r;
  logic [48:0] recip_prod;

  // quotient sits at bit 34 and above in the reciprocal product
  assign recip_prod = 49'(prod_r) * 49'(SCALE_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      mul_v_r <= start;
      done_r  <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start)   prod_r <= 24'(level) * 24'(period);
    if (mul_v_r) quot_r <= {1'b0, recip_prod[48:34]};
  end

  assign done   = done_r;
  assign result = quot_r;

endmodule

// ===== rtl/core/rgb_led_button_mode_controller.sv =====
// ----------------------------------------------------------------------------
// rgb_led_button_mode_controller
// Two-button mode and brightness controller producing three pwm pulse widths.
// ----------------------------------------------------------------------------
// One input word is one 10 ms tick with the two button levels. It is taken
// when in_valid is high and in_stall low; in_stall stays high while a tick is
// being worked on. Each tick yields one output word: three pulse widths, the
// mode and the colour bits.
// The colour tick counter is wrapped by subtracting the cycle period (at most
// twice), then each channel that needs a new width goes through the shared
// scale unit, a multiply and a reciprocal multiply for the divide by 1000,
// three channels at most. Only one tick is in flight; the next is taken the
// cycle after the output register has been loaded.
// If the receiver stalls, the word holds in the output register; the next tick
// can still be taken and worked on, but it then waits with in_stall high until
// the held word leaves.
// Configuration writes (cfg_ready is always high) should only be made while
// idle. Reset restores registers, levels 83, period 50, colour red and widths
// of 943; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rgb_led_button_mode_controller
  import rgbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_first_button_down,
  input  logic        in_second_button_down,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_red_pulse_width,
  output logic [15:0] out_blue_pulse_width,
  output logic [15:0] out_green_pulse_width,
  output logic [1:0]  out_active_mode,
  output logic [3:0]  out_colour_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  seq_state_t  state_r, state_nxt;

  logic [15:0] pwm_period_r, long_ticks_r, short_ticks_r;
  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] hold1_r, hold1_nxt, hold2_r, hold2_nxt;
  logic [7:0]  g1_r, g1_nxt, g2_r, g2_nxt;
  logic [7:0]  lvl_r [3];
  logic [7:0]  lvl_nxt [3];
  logic [6:0]  cp_r, cp_nxt;
  logic [6:0]  tick_r;
  logic [3:0]  colour_r;
  logic [15:0] width_r [3];
  logic        short0_r, short0_nxt;
  logic [2:0]  wr_r, scl_r;
  logic [1:0]  ch_r;
  logic        out_valid_r;
  logic [15:0] out_w_r [3];
  logic [1:0]  out_mode_r;
  logic [3:0]  out_colour_r;

  press_cls_t  f1, f2;
  logic        in_acc, wrap;
  logic [3:0]  colour_new;
  logic        unit_start, unit_done;
  logic [15:0] unit_result;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // press classification of the two buttons
  always_comb begin
    hold1_nxt = hold1_r;
    hold2_nxt = hold2_r;
    if (in_first_button_down) begin
      f1 = CLS_HELD;
      if (hold1_r != HOLD_MAX) hold1_nxt = hold1_r + 16'd1;
    end else begin
      hold1_nxt = '0;
      if (hold1_r >= long_ticks_r)       f1 = CLS_LONG;
      else if (hold1_r >= short_ticks_r) f1 = CLS_SHORT;
      else                               f1 = CLS_NONE;
    end
    if (in_second_button_down) begin
      f2 = CLS_HELD;
      if (hold2_r != HOLD_MAX) hold2_nxt = hold2_r + 16'd1;
    end else begin
      hold2_nxt = '0;
      if (hold2_r >= long_ticks_r)       f2 = CLS_LONG;
      else if (hold2_r >= short_ticks_r) f2 = CLS_SHORT;
      else                               f2 = CLS_NONE;
    end
  end

  // gestures and short press actions
  always_comb begin
    logic       do_short, up;
    logic [1:0] sel;
    mode_nxt   = mode_r;
    g1_nxt     = g1_r;
    g2_nxt     = g2_r;
    cp_nxt     = cp_r;
    lvl_nxt    = lvl_r;
    short0_nxt = 1'b0;
    do_short   = 1'b0;
    up         = 1'b0;
    sel        = 2'(mode_r - 2'd1);
    if (f2 == CLS_HELD && f1 == CLS_SHORT) begin
      g1_nxt = (g1_r == 8'd2) ? 8'd2 : 8'(g1_r + 8'd1);
    end else if (f2 == CLS_HELD && f1 == CLS_LONG) begin
      g1_nxt = 8'd3;
    end else if (f2 == CLS_LONG && g1_r == 8'd1) begin
      mode_nxt = 2'd1;
    end else if (f2 == CLS_LONG && g1_r == 8'd2) begin
      mode_nxt = 2'd2;
    end else if ((f2 == CLS_LONG && g1_r == 8'd3) || (f1 == CLS_LONG && g2_r == 8'd3)) begin
      mode_nxt = 2'd3;
    end else if (f1 == CLS_HELD && f2 == CLS_LONG) begin
      g2_nxt = 8'd3;
    end else if (f1 == CLS_NONE && f2 == CLS_SHORT) begin
      do_short = 1'b1;
      up       = 1'b1;
    end else if (f2 == CLS_NONE && f1 == CLS_SHORT) begin
      do_short = 1'b1;
    end
    if (do_short) begin
      if (mode_r == 2'd0) begin
        short0_nxt = 1'b1;
        if (up) cp_nxt = (cp_r + PERIOD_STEP > PERIOD_MAX) ? PERIOD_MAX : cp_r + PERIOD_STEP;
        else    cp_nxt = (cp_r <= PERIOD_LOW_EDGE) ? PERIOD_MIN : cp_r - PERIOD_STEP;
      end else if (up) begin
        lvl_nxt[sel] = (lvl_r[sel] > LEVEL_TOP_EDGE) ? LEVEL_MAX : lvl_r[sel] + LEVEL_STEP;
      end else begin
        lvl_nxt[sel] = (lvl_r[sel] <= LEVEL_MIN) ? LEVEL_MIN : lvl_r[sel] - LEVEL_STEP;
      end
    end
    if (f1 == CLS_NONE) g2_nxt = '0;
    if (f2 == CLS_NONE) g1_nxt = '0;
  end

  assign wrap       = (tick_r == 7'd0);
  assign colour_new = next_colour(colour_r);

  always_comb begin
    state_nxt  = state_r;
    unit_start = 1'b0;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_MOD;
      ST_MOD:   if (tick_r < cp_r) state_nxt = ST_PLAN;
      ST_PLAN:  state_nxt = ST_CHAN;
      ST_CHAN: begin
        if (ch_r == 2'd3) begin
          state_nxt = ST_OUT;
        end else if (wr_r[ch_r] && scl_r[ch_r]) begin
          unit_start = 1'b1;
          state_nxt  = ST_SCALE;
        end
      end
      ST_SCALE: if (unit_done) state_nxt = ST_CHAN;
      ST_OUT:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r  <= 16'd11362;
      long_ticks_r  <= 16'd100;
      short_ticks_r <= 16'd2;
      mode_r        <= '0;
      hold1_r       <= '0;
      hold2_r       <= '0;
      g1_r          <= '0;
      g2_r          <= '0;
      lvl_r         <= '{LEVEL_RESET, LEVEL_RESET, LEVEL_RESET};
      cp_r          <= PERIOD_RESET;
      tick_r        <= '0;
      colour_r      <= COLOUR_RESET;
      width_r       <= '{WIDTH_RESET, WIDTH_RESET, WIDTH_RESET};
      short0_r      <= 1'b0;
      wr_r          <= '0;
      scl_r         <= '0;
      ch_r          <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PWM_PERIOD:  pwm_period_r  <= cfg_data;
          REG_LONG_TICKS:  long_ticks_r  <= cfg_data;
          REG_SHORT_TICKS: short_ticks_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            hold1_r  <= hold1_nxt;
            hold2_r  <= hold2_nxt;
            mode_r   <= mode_nxt;
            g1_r     <= g1_nxt;
            g2_r     <= g2_nxt;
            lvl_r    <= lvl_nxt;
            cp_r     <= cp_nxt;
            short0_r <= short0_nxt;
            tick_r   <= tick_r + 7'd1;
          end
        end
        ST_MOD: begin
          if (tick_r >= cp_r) tick_r <= tick_r - cp_r;
        end
        ST_PLAN: begin
          ch_r <= '0;
          if (mode_r != 2'd0) begin
            wr_r  <= 3'b111;
            scl_r <= 3'b111;
          end else if (wrap || short0_r) begin
            wr_r  <= 3'b111;
            scl_r <= wrap ? {colour_new[3], colour_new[2], colour_new[1]}
                          : {colour_r[3], colour_r[2], colour_r[1]};
            if (wrap) colour_r <= colour_new;
          end else begin
            wr_r  <= '0;
            scl_r <= '0;
          end
        end
        ST_CHAN: begin
          if (ch_r != 2'd3 && !(wr_r[ch_r] && scl_r[ch_r])) begin
            if (wr_r[ch_r]) width_r[ch_r] <= WIDTH_OFF;
            ch_r <= ch_r + 2'd1;
          end
        end
        ST_SCALE: begin
          if (unit_done) begin
            width_r[ch_r] <= unit_result;
            ch_r          <= ch_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      out_w_r      <= width_r;
      out_mode_r   <= mode_r;
      out_colour_r <= colour_r;
    end
  end

  rgbl_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (unit_start),
    .level  (lvl_r[ch_r[1:0] == 2'd3 ? 2'd2 : ch_r]),
    .period (pwm_period_r),
    .done   (unit_done),
    .result (unit_result)
  );

  assign out_valid             = out_valid_r;
  assign out_red_pulse_width   = out_w_r[0];
  assign out_blue_pulse_width  = out_w_r[1];
  assign out_green_pulse_width = out_w_r[2];
  assign out_active_mode       = out_mode_r;
  assign out_colour_code       = out_colour_r;

  a_mode_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != 2'd0) |=> (mode_r != 2'd0))
    else $error("mode returned to colour cycling");

  a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cp_r >= PERIOD_MIN) && (cp_r <= PERIOD_MAX))
    else $error("cycle period out of range");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("output word raised outside output state");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rgb led button mode controller: a short table of
// button ticks, then random press sequences and gestures under several
// threshold and period settings, each output word checked against the predictor, the first one against a table value.
// ----------------------------------------------------------------------------
module testbench
  import rgbl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] blue;
    logic [15:0] green;
    logic [1:0]  mode;
    logic [3:0]  colour;
  } led_word_t;

  typedef struct packed {
    bit        first;
    bit        second;
    bit        typed;
    led_word_t word;
  } tick_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_first_button_down;
  logic        in_second_button_down;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_red_pulse_width;
  logic [15:0] out_blue_pulse_width;
  logic [15:0] out_green_pulse_width;
  logic [1:0]  out_active_mode;
  logic [3:0]  out_colour_code;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  rgb_led_button_mode_controller dut (.*);

  // predictor copy of configuration and state
  logic [15:0] period_cfg, long_cfg, short_cfg;
  logic [1:0]  mode_q;
  logic [15:0] hold1_q, hold2_q;
  logic [7:0]  gest1_q, gest2_q;
  logic [7:0]  lvl_q [3];  // red, blue, green
  logic [7:0]  cyc_period_q, cyc_tick_q;
  logic [3:0]  colour_q;
  logic [15:0] width_q [3];

  led_word_t   expected_words [$];
  tick_row_t   dir_rows [$];
  int          errors = 0;
  int          snd_idle = 0, rcv_idle = 0;
  int          ticks_sent;

  function automatic logic [15:0] scaled_width(input logic [7:0] lvl);
    logic [31:0] p;
    p = 32'(lvl) * 32'(period_cfg);
    return 16'(p / 1000);
  endfunction

  function automatic press_cls_t press_class(input bit down, inout logic [15:0] hold);
    press_cls_t c;
    if (down) begin
      if (hold != HOLD_MAX) hold = hold + 16'd1;
      return CLS_HELD;
    end
    if (hold >= long_cfg) c = CLS_LONG;
    else if (hold >= short_cfg) c = CLS_SHORT;
    else c = CLS_NONE;
    hold = '0;
    return c;
  endfunction

  task automatic refresh_colour();
    width_q[2] = colour_q[3] ? scaled_width(lvl_q[2]) : WIDTH_OFF;
    width_q[1] = colour_q[2] ? scaled_width(lvl_q[1]) : WIDTH_OFF;
    width_q[0] = colour_q[1] ? scaled_width(lvl_q[0]) : WIDTH_OFF;
  endtask

  task automatic adjust_short(input bit up);
    int idx;
    if (mode_q == 2'd0) begin
      if (up) cyc_period_q = (cyc_period_q + 5 > 100) ? 8'd100 : cyc_period_q + 8'd5;
      else cyc_period_q = (cyc_period_q <= 10) ? 8'd5 : cyc_period_q - 8'd5;
      refresh_colour();
    end else begin
      idx = int'(mode_q) - 1;
      if (up) lvl_q[idx] = (lvl_q[idx] > 240) ? 8'd254 : lvl_q[idx] + 8'd10;
      else lvl_q[idx] = (lvl_q[idx] <= 10) ? 8'd10 : lvl_q[idx] - 8'd10;
      width_q[idx] = scaled_width(lvl_q[idx]);
    end
  endtask

  task automatic predict_tick(input bit b1, input bit b2, output led_word_t w);
    press_cls_t f1, f2;
    f1 = press_class(b1, hold1_q);
    f2 = press_class(b2, hold2_q);
    if (f2 == CLS_HELD && f1 == CLS_SHORT) begin
      gest1_q = gest1_q + 8'd1;
      if (gest1_q == 8'd3) gest1_q = 8'd2;
    end else if (f2 == CLS_HELD && f1 == CLS_LONG) gest1_q = 8'd3;
    else if (f2 == CLS_LONG && gest1_q == 8'd1) mode_q = 2'd1;
    else if (f2 == CLS_LONG && gest1_q == 8'd2) mode_q = 2'd2;
    else if ((f2 == CLS_LONG && gest1_q == 8'd3) || (f1 == CLS_LONG && gest2_q == 8'd3))
      mode_q = 2'd3;
    else if (f1 == CLS_HELD && f2 == CLS_LONG) gest2_q = 8'd3;
    else if (f1 == CLS_NONE && f2 == CLS_SHORT) adjust_short(1'b1);
    else if (f2 == CLS_NONE && f1 == CLS_SHORT) adjust_short(1'b0);
    if (f1 == CLS_NONE) gest2_q = '0;
    if (f2 == CLS_NONE) gest1_q = '0;

    cyc_tick_q = 8'((int'(cyc_tick_q) + 1) % (cyc_period_q != 0 ? int'(cyc_period_q) : 1));
    if (mode_q == 2'd0) begin
      if (cyc_tick_q == 0) begin
        case (colour_q)
          4'd2:  colour_q = 4'd10;
          4'd10: colour_q = 4'd8;
          4'd8:  colour_q = 4'd12;
          4'd12: colour_q = 4'd4;
          4'd4:  colour_q = 4'd6;
          4'd6:  colour_q = 4'd2;
          default: ;
        endcase
        refresh_colour();
      end
    end else begin
      for (int i = 0; i < 3; i++) width_q[i] = scaled_width(lvl_q[i]);
    end
    w = '{width_q[0], width_q[1], width_q[2], mode_q, colour_q};
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // receiver stall
  always @(negedge clk) out_stall <= ($urandom_range(99) < rcv_idle);

  always @(posedge clk) begin
    led_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (out_red_pulse_width !== w.red) begin
          $error("red_pulse_width exp %0d got %0d", w.red, out_red_pulse_width); errors++;
        end
        if (out_blue_pulse_width !== w.blue) begin
          $error("blue_pulse_width exp %0d got %0d", w.blue, out_blue_pulse_width); errors++;
        end
        if (out_green_pulse_width !== w.green) begin
          $error("green_pulse_width exp %0d got %0d", w.green, out_green_pulse_width);
          errors++;
        end
        if (out_active_mode !== w.mode) begin
          $error("active_mode exp %0d got %0d", w.mode, out_active_mode); errors++;
        end
        if (out_colour_code !== w.colour) begin
          $error("colour_code exp %0d got %0d", w.colour, out_colour_code); errors++;
        end
      end
    end
  end

  task automatic send_tick(input bit b1, input bit b2, input bit typed, input led_word_t tw);
    led_word_t w;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_first_button_down <= b1;
    in_second_button_down <= b2;
    do @(posedge clk); while (in_stall);
    predict_tick(b1, b2, w);
    expected_words.push_back(typed ? tw : w);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic hold_buttons(input bit b1, input bit b2, input int n);
    for (int i = 0; i < n; i++) send_tick(b1, b2, 1'b0, '0);
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PWM_PERIOD:  period_cfg = val;
      REG_LONG_TICKS:  long_cfg = val;
      REG_SHORT_TICKS: short_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int press_len();
    int lim;
    case ($urandom_range(3))
      0: return 1;
      1: lim = int'(short_cfg);
      2: lim = int'(long_cfg);
      default: return $urandom_range(1, 20);
    endcase
    if (lim > 20) lim = $urandom_range(2, 20);
    return $urandom_range(lim > 1 ? lim - 1 : 1, lim + 1);
  endfunction

  // mostly well-formed presses and gestures, some noise
  task automatic random_ticks(input int n);
    int stop_at, k;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      case ($urandom_range(9))
        0: send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
        1, 2: begin
          // second held, first tapped, then second released
          k = $urandom_range(1, 3);
          for (int i = 0; i < k; i++) begin
            hold_buttons(1'b1, 1'b1, press_len());
            hold_buttons(1'b0, 1'b1, 1);
          end
          hold_buttons(1'b0, 1'b1, press_len());
          hold_buttons(1'b0, 1'b0, 1);
        end
        3: begin
          // first held across a second press, then first released
          hold_buttons(1'b1, 1'b1, press_len());
          hold_buttons(1'b1, 1'b0, press_len());
          hold_buttons(1'b0, 1'b0, 1);
        end
        default: begin
          hold_buttons(1'($urandom_range(1)), 1'($urandom_range(1)), press_len());
          hold_buttons(1'b0, 1'b0, $urandom_range(1, 2));
        end
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_first_button_down = 1'b0;
    in_second_button_down = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_PWM_PERIOD;
    cfg_data = '0;
    ticks_sent = 0;
    period_cfg = 16'd11362; long_cfg = 16'd100; short_cfg = 16'd2;
    mode_q = '0; hold1_q = '0; hold2_q = '0; gest1_q = '0; gest2_q = '0;
    lvl_q = '{LEVEL_RESET, LEVEL_RESET, LEVEL_RESET};
    cyc_period_q = 8'(PERIOD_RESET); cyc_tick_q = '0; colour_q = COLOUR_RESET;
    width_q = '{WIDTH_RESET, WIDTH_RESET, WIDTH_RESET};

    // first word after reset reads off directly; the rest go to the predictor
    dir_rows.push_back('{1'b0, 1'b0, 1'b1, '{16'd943, 16'd943, 16'd943, 2'd0, 4'd2}});
    dir_rows.push_back('{1'b0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{1'b0, 1'b1, 1'b0, '0});  // second short: period up
    dir_rows.push_back('{1'b0, 1'b1, 1'b0, '0});
    dir_rows.push_back('{1'b0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{1'b1, 1'b0, 1'b0, '0});  // first short: period down
    dir_rows.push_back('{1'b1, 1'b0, 1'b0, '0});
    dir_rows.push_back('{1'b1, 1'b0, 1'b0, '0});
    dir_rows.push_back('{1'b0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{1'b1, 1'b0, 1'b0, '0});  // tap too short
    dir_rows.push_back('{1'b0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{1'b1, 1'b1, 1'b0, '0});  // both released together
    dir_rows.push_back('{1'b1, 1'b1, 1'b0, '0});
    dir_rows.push_back('{1'b0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{1'b0, 1'b1, 1'b0, '0});
    dir_rows.push_back('{1'b1, 1'b1, 1'b0, '0});
    dir_rows.push_back('{1'b0, 1'b1, 1'b0, '0});
    dir_rows.push_back('{1'b0, 1'b0, 1'b0, '0});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_tick(dir_rows[i].first, dir_rows[i].second,
                                    dir_rows[i].typed, dir_rows[i].word);
    drain_words();

    // stays in colour cycling: no release can reach the long threshold
    snd_idle = 22; rcv_idle = 85;
    write_reg(REG_PWM_PERIOD, 16'd1);
    write_reg(REG_LONG_TICKS, 16'hFFFF);
    write_reg(REG_SHORT_TICKS, 16'd1);
    random_ticks(150);
    drain_words();

    snd_idle = 85; rcv_idle = 22;
    write_reg(REG_PWM_PERIOD, 16'hFFFF);
    write_reg(REG_LONG_TICKS, 16'd6);
    write_reg(REG_SHORT_TICKS, 16'd2);
    random_ticks(150);
    drain_words();

    snd_idle = 0; rcv_idle = 0;
    write_reg(REG_PWM_PERIOD, 16'($urandom_range(1, 65535)));
    write_reg(REG_LONG_TICKS, 16'd1);
    write_reg(REG_SHORT_TICKS, 16'hFFFF);
    random_ticks(100);
    drain_words();

    write_reg(REG_PWM_PERIOD, 16'($urandom_range(1, 65535)));
    write_reg(REG_LONG_TICKS, 16'd9);
    write_reg(REG_SHORT_TICKS, 16'd3);
    random_ticks(200);

    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (120) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
